// File: rtl/glossy_specular_lobe_assert.svh
// Assertion macros shared by the glossy specular lobe RTL.
`ifndef GLOSSY_SPECULAR_LOBE_ASSERT_SVH
`define GLOSSY_SPECULAR_LOBE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GSL_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("glossy_specular_lobe: check failed");
`define GSL_ASSERT_NEVER(lbl, cond) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) !(cond)) else $error("glossy_specular_lobe: forbidden condition");
`else
`define GSL_ASSERT(lbl, prop)
`define GSL_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/gsl_pkg.sv
// Types, constants and register map of the glossy specular lobe.
package gsl_pkg;
  localparam int unsigned FracBitsDefault = 14;
  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned SW = 55;
  localparam int unsigned AddrW = 5;

  localparam logic [2:0] REG_STRENGTH = 3'd0;
  localparam logic [2:0] REG_COLOUR_RED = 3'd1;
  localparam logic [2:0] REG_COLOUR_GREEN = 3'd2;
  localparam logic [2:0] REG_COLOUR_BLUE = 3'd3;
  localparam logic [2:0] REG_EXPONENT = 3'd4;

  typedef enum logic [1:0] {
    CLS_BLACK,
    CLS_ONE,
    CLS_POW
  } cls_e;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } out_item_t;

  typedef struct packed {
    cls_e cls;
    logic [SW-1:0] s;
  } mid_item_t;

  typedef struct packed {
    logic [15:0] strength;
    logic [15:0] colour_red;
    logic [15:0] colour_green;
    logic [15:0] colour_blue;
    logic [15:0] exponent;
  } cfg_t;
endpackage

// File: rtl/gsl_fifo.sv
// Small first-in first-out queue built from registers.
module gsl_fifo #(
  parameter type data_t = logic,
  parameter int unsigned DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  data_t wdata_i,
  input  logic  pop_i,
  output data_t rdata_o,
  output logic  empty_o,
  output logic  full_o
);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  data_t mem_q [DEPTH];
  logic [IW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + IW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + IW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end
endmodule

// File: rtl/gsl_front.sv
// Front pipeline: reflection, lobe dot product and classification.
module gsl_front #(
  parameter int unsigned FRAC_BITS = gsl_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  gsl_pkg::in_item_t  item_i,
  output logic               valid_o,
  output gsl_pkg::mid_item_t item_o
);
  import gsl_pkg::*;

  localparam int unsigned PW = 32;
  localparam int unsigned DW = 33;
  localparam int unsigned NDW = 26;
  localparam int unsigned MW = 43;
  localparam int unsigned RW = 37;
  localparam int unsigned QW = 53;
  localparam logic signed [63:0] OneSq = 64'sd1 <<< (2 * FRAC_BITS);

  logic [5:0] vld_q;
  logic signed [15:0] n0 [3], l0 [3], v0 [3];
  logic signed [15:0] n1_q [3], n2_q [3];
  logic signed [15:0] l1_q [3], l2_q [3], l3_q [3];
  logic signed [15:0] v1_q [3], v2_q [3], v3_q [3], v4_q [3];
  logic signed [PW-1:0] prod_q [3];
  logic signed [DW-1:0] d_sum;
  logic signed [NDW-1:0] nd_q;
  logic signed [MW-1:0] m_q [3];
  logic signed [RW-1:0] r_q [3];
  logic signed [QW-1:0] q_q [3];
  logic signed [SW-1:0] s_sum;
  logic signed [63:0] s64;
  mid_item_t item_q;

  assign n0[0] = item_i.normal_x;
  assign n0[1] = item_i.normal_y;
  assign n0[2] = item_i.normal_z;
  assign l0[0] = item_i.light_x;
  assign l0[1] = item_i.light_y;
  assign l0[2] = item_i.light_z;
  assign v0[0] = item_i.view_x;
  assign v0[1] = item_i.view_y;
  assign v0[2] = item_i.view_z;

  assign d_sum = DW'(prod_q[0]) + DW'(prod_q[1]) + DW'(prod_q[2]);
  assign s_sum = SW'(q_q[0]) + SW'(q_q[1]) + SW'(q_q[2]);
  assign s64 = 64'(s_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= PW'(n0[i] * l0[i]);
      n1_q[i] <= n0[i];
      n2_q[i] <= n1_q[i];
      l1_q[i] <= l0[i];
      l2_q[i] <= l1_q[i];
      l3_q[i] <= l2_q[i];
      v1_q[i] <= v0[i];
      v2_q[i] <= v1_q[i];
      v3_q[i] <= v2_q[i];
      v4_q[i] <= v3_q[i];
      m_q[i] <= (MW'(n2_q[i]) * MW'(nd_q)) <<< 1;
      r_q[i] <= RW'(m_q[i] >>> FRAC_BITS) - RW'(l3_q[i]);
      q_q[i] <= QW'(r_q[i]) * QW'(v4_q[i]);
    end
    nd_q <= NDW'(d_sum >>> FRAC_BITS);
    item_q.s <= s_sum;
    if (s_sum <= 0) begin
      item_q.cls <= CLS_BLACK;
    end else if (s64 >= OneSq) begin
      item_q.cls <= CLS_ONE;
    end else begin
      item_q.cls <= CLS_POW;
    end
  end

  assign valid_o = vld_q[5];
  assign item_o = item_q;
endmodule

// File: rtl/gsl_back.sv
// Back pipeline: log2/exp2 power, strength and colour scaling.
module gsl_back #(
  parameter int unsigned FRAC_BITS = gsl_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  gsl_pkg::mid_item_t item_i,
  input  gsl_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output gsl_pkg::out_item_t item_o
);
  import gsl_pkg::*;

  localparam int unsigned AW = 23;
  localparam int unsigned EW = 31;
  localparam int unsigned NW = 48;
  localparam int unsigned PWR = 31;
  localparam int unsigned SSW = 47;
  localparam int unsigned CPW = 63;

  logic [5:0] vld_q;
  cls_e cls1_q, cls2_q, cls3_q;
  logic [SW-1:0] s1_q;
  logic [5:0] p_d, p1_q;
  logic [SW-1:0] norm;
  logic [15:0] frac;
  logic [AW-1:0] a_q;
  logic [38:0] e_prod;
  logic [EW-1:0] e_q;
  logic [14:0] k;
  logic [NW-1:0] num;
  logic [PWR-1:0] pw_d, pw_q;
  logic [SSW-1:0] ps_q;
  logic [CPW-1:0] cr, cg, cb;
  out_item_t item_q;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < SW; i++) begin
      if (item_i.s[i]) begin
        p_d = 6'(i);
      end
    end
  end

  assign norm = s1_q << (6'(SW - 1) - p1_q);
  assign frac = norm[SW-2 -: 16];
  assign e_prod = 39'(a_q) * 39'(cfg_i.exponent);
  assign k = e_q[EW-1:16];
  assign num = NW'(18'd131072 - 18'(e_q[15:0])) << FRAC_BITS;

  always_comb begin
    if (k >= 15'd46) begin
      pw_d = '0;
    end else begin
      pw_d = PWR'(num >> (k + 15'd17));
    end
    case (cls3_q)
      CLS_BLACK: pw_d = '0;
      CLS_ONE: pw_d = PWR'(1) << FRAC_BITS;
      default: ;
    endcase
  end

  assign cr = (CPW'(ps_q) * CPW'(cfg_i.colour_red)) >> (FRAC_BITS + 15);
  assign cg = (CPW'(ps_q) * CPW'(cfg_i.colour_green)) >> (FRAC_BITS + 15);
  assign cb = (CPW'(ps_q) * CPW'(cfg_i.colour_blue)) >> (FRAC_BITS + 15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cls1_q <= item_i.cls;
    s1_q <= item_i.s;
    p1_q <= p_d;
    cls2_q <= cls1_q;
    a_q <= (AW'(7'(2 * FRAC_BITS) - 7'(p1_q)) << 16) - AW'(frac);
    cls3_q <= cls2_q;
    e_q <= EW'(e_prod >> 8);
    pw_q <= pw_d;
    ps_q <= SSW'(pw_q) * SSW'(cfg_i.strength);
    item_q.out_red <= (cr > CPW'(65535)) ? 16'hFFFF : cr[15:0];
    item_q.out_green <= (cg > CPW'(65535)) ? 16'hFFFF : cg[15:0];
    item_q.out_blue <= (cb > CPW'(65535)) ? 16'hFFFF : cb[15:0];
  end

  assign valid_o = vld_q[5];
  assign item_o = item_q;
endmodule

// File: rtl/glossy_specular_lobe.sv
// Top level of the glossy specular lobe with its register port.
// Path: a result reaches the queue head after 6 front stages (the first registered at the edge
// that accepts its item), 1 middle queue, 6 back stages and 1 result queue, later while
// results are not popped.
// Throughput: one item per cycle; credit counters sized by QUEUE_DEPTH bound it.
// Reset empties the queues, clears the pipeline valid bits and sets the registers to their default values.
module glossy_specular_lobe #(
  parameter int unsigned FRAC_BITS = gsl_pkg::FracBitsDefault,
  parameter int unsigned QUEUE_DEPTH = gsl_pkg::QueueDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  gsl_pkg::in_item_t          in_data_i,
  output logic                       empty,
  input  logic                       pop,
  output gsl_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gsl_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gsl_pkg::*;
  `include "glossy_specular_lobe_assert.svh"

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t cfg_q, cfg_d;
  logic [CW-1:0] fcred_q, fcred_d, bcred_q, bcred_d;
  logic in_acc, mid_pop, out_pop;
  logic front_vld, back_vld;
  mid_item_t front_item, mid_item;
  out_item_t back_item;
  logic mid_empty, mid_full, out_full;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign full = (fcred_q == CW'(QUEUE_DEPTH));
  assign in_acc = push && !full;
  assign mid_pop = !mid_empty && (bcred_q != CW'(QUEUE_DEPTH));
  assign out_pop = pop && !empty;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_STRENGTH: cfg_d.strength = pwdata[15:0];
        REG_COLOUR_RED: cfg_d.colour_red = pwdata[15:0];
        REG_COLOUR_GREEN: cfg_d.colour_green = pwdata[15:0];
        REG_COLOUR_BLUE: cfg_d.colour_blue = pwdata[15:0];
        REG_EXPONENT: cfg_d.exponent = pwdata[15:0];
        default: ;
      endcase
    end
    unique case (ridx)
      REG_STRENGTH: prdata = {16'h0, cfg_q.strength};
      REG_COLOUR_RED: prdata = {16'h0, cfg_q.colour_red};
      REG_COLOUR_GREEN: prdata = {16'h0, cfg_q.colour_green};
      REG_COLOUR_BLUE: prdata = {16'h0, cfg_q.colour_blue};
      REG_EXPONENT: prdata = {16'h0, cfg_q.exponent};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    fcred_d = fcred_q;
    bcred_d = bcred_q;
    if (in_acc && !mid_pop) begin
      fcred_d = fcred_q + CW'(1);
    end else if (!in_acc && mid_pop) begin
      fcred_d = fcred_q - CW'(1);
    end
    if (mid_pop && !out_pop) begin
      bcred_d = bcred_q + CW'(1);
    end else if (!mid_pop && out_pop) begin
      bcred_d = bcred_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strength <= 16'd0;
      cfg_q.colour_red <= 16'd16384;
      cfg_q.colour_green <= 16'd16384;
      cfg_q.colour_blue <= 16'd16384;
      cfg_q.exponent <= 16'd256;
      fcred_q <= '0;
      bcred_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      fcred_q <= fcred_d;
      bcred_q <= bcred_d;
    end
  end

  gsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .valid_i(in_acc),
    .item_i (in_data_i),
    .valid_o(front_vld),
    .item_o (front_item)
  );

  gsl_fifo #(.data_t(mid_item_t), .DEPTH(QUEUE_DEPTH)) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .push_i (front_vld),
    .wdata_i(front_item),
    .pop_i  (mid_pop),
    .rdata_o(mid_item),
    .empty_o(mid_empty),
    .full_o (mid_full)
  );

  gsl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .valid_i(mid_pop),
    .item_i (mid_item),
    .cfg_i  (cfg_q),
    .valid_o(back_vld),
    .item_o (back_item)
  );

  gsl_fifo #(.data_t(out_item_t), .DEPTH(QUEUE_DEPTH)) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i (back_vld),
    .wdata_i(back_item),
    .pop_i  (out_pop),
    .rdata_o(out_data_o),
    .empty_o(empty),
    .full_o (out_full)
  );

  `GSL_ASSERT_NEVER(a_mid_overflow, front_vld && mid_full)
  `GSL_ASSERT_NEVER(a_out_overflow, back_vld && out_full)
  `GSL_ASSERT(a_fcred_bound, fcred_q <= CW'(QUEUE_DEPTH))
  `GSL_ASSERT(a_bcred_bound, bcred_q <= CW'(QUEUE_DEPTH))
endmodule
